>>> rtl/tdfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfc_pkg
// Shared types and constants of the two-dimensional follow chain IK block.
// ----------------------------------------------------------------------------
package tdfc_pkg;

    localparam int NUM_SEGS  = 32;
    localparam int SEG_W     = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [13:0] ROOT_RESET  = 14'd6400;
    localparam logic [13:0] LEN_RESET   = 14'd16;
    localparam logic [14:0] REACH_RESET = 15'd512;
    localparam logic signed [15:0] DIR_ONE = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT_X      = 2'd0,
        CFG_ROOT_Y      = 2'd1,
        CFG_SEG_LENGTH  = 2'd2,
        CFG_REACH_LIMIT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0] target_x;
        logic [9:0] target_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               is_last;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_C_SQX,
        ST_C_SQY,
        ST_C_R2,
        ST_C_CMP,
        ST_C_MX,
        ST_C_DX,
        ST_C_MY,
        ST_C_DY,
        ST_C_FIN,
        ST_SQRT,
        ST_DIV,
        ST_B_VEC,
        ST_B_SQX,
        ST_B_SQY,
        ST_B_SUM,
        ST_B_DX,
        ST_B_DY,
        ST_B_UY,
        ST_B_MX,
        ST_B_MY,
        ST_B_SY,
        ST_F_OUT,
        ST_F_MY,
        ST_F_NY
    } state_t;

endpackage

>>> rtl/two_d_follow_chain_ik.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_d_follow_chain_ik
// FABRIK-style 2D chain solver: target clamp, backward pass, forward pass.
// ----------------------------------------------------------------------------
// Each accepted target runs the whole solve on one sequencer around a shared
// registered 20x20 multiplier, a bit-serial square root and a restoring
// divider. Each segment of the backward pass takes a square root and two
// divisions unless its aim has zero length; the reach clamp takes a square
// root and two divisions only when the target lies beyond reach. The forward
// pass emits one point per segment and waits out any output stalls.
// s_ready is high only between items.
// Results leave through a one-deep output register.
// ----------------------------------------------------------------------------
module two_d_follow_chain_ik (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tdfc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tdfc_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [tdfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdfc_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int N     = tdfc_pkg::NUM_SEGS;
    localparam int SW    = tdfc_pkg::SEG_W;
    localparam int SQW   = 44;
    localparam int DENW  = 22;
    localparam int DIVW  = 36;
    localparam int DCW   = 6;

    tdfc_pkg::state_t state_reg, state_next, ret_reg;

    logic [13:0] root_x_reg, root_y_reg, len_reg;
    logic [14:0] reach_reg;

    logic signed [15:0] start_x_reg [N];
    logic signed [15:0] start_y_reg [N];
    logic signed [15:0] dir_x_reg   [N];
    logic signed [15:0] dir_y_reg   [N];

    logic [SW-1:0]        seg_reg;
    logic signed [15:0]   dx_reg, dy_reg;
    logic signed [16:0]   px_reg, py_reg;
    logic signed [17:0]   vx_reg, vy_reg;
    logic signed [15:0]   ux_reg, uy_reg;
    logic [35:0]          sum_reg;
    logic signed [39:0]   prod_reg;

    logic [SQW-1:0]       sq_v_reg, sq_r_reg, sq_b_reg;
    logic [DENW-1:0]      den_reg;
    logic [DIVW-1:0]      div_n_reg;
    logic [DENW-1:0]      div_rem_reg;
    logic [DCW-1:0]       div_cnt_reg;
    logic                 div_neg_reg;

    logic                 m_valid_reg;
    tdfc_pkg::out_item_t  m_data_reg;

    logic signed [19:0]   mul_a, mul_b;
    logic signed [17:0]   vx_c, vy_c;
    logic [39:0]          prod_abs;
    logic [39:0]          step_mag;
    logic signed [17:0]   step_c;
    logic signed [15:0]   sub_sat, add_sat;
    logic [SQW-1:0]       sq_t, sq_r_next;
    logic                 sq_ge;
    logic [DENW:0]        rem_sh;
    logic                 q_bit;
    logic signed [40:0]   div_src;
    logic [40:0]          div_abs;
    logic [DIVW-1:0]      div_init;
    logic signed [DIVW:0] div_q;
    logic signed [15:0]   dir_q;
    logic [35:0]          sum_add;
    logic                 out_free;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sd32767;
        end else if (v < -18'sd32768) begin
            return -16'sd32768;
        end
        return 16'(v);
    endfunction

    // ---- combinational datapath
    assign vx_c     = 18'(px_reg) - 18'(start_x_reg[seg_reg]);
    assign vy_c     = 18'(py_reg) - 18'(start_y_reg[seg_reg]);
    assign prod_abs = prod_reg[39] ? 40'(-prod_reg) : 40'(prod_reg);
    assign step_mag = (prod_abs + 40'd8192) >> 14;
    assign step_c   = prod_reg[39] ? -$signed(18'(step_mag)) : $signed(18'(step_mag));
    assign sum_add  = sum_reg + 36'(prod_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        sub_sat = 16'sd0;
        add_sat = 16'sd0;
        unique case (state_reg)
            tdfc_pkg::ST_B_MY, tdfc_pkg::ST_F_MY: begin
                sub_sat = sat16(18'(px_reg) - step_c);
                add_sat = sat16(18'(px_reg) + step_c);
            end
            tdfc_pkg::ST_B_SY, tdfc_pkg::ST_F_NY: begin
                sub_sat = sat16(18'(py_reg) - step_c);
                add_sat = sat16(18'(py_reg) + step_c);
            end
            default: begin
            end
        endcase
    end

    assign sq_t      = sq_r_reg + sq_b_reg;
    assign sq_ge     = sq_v_reg >= sq_t;
    assign sq_r_next = sq_ge ? ((sq_r_reg >> 1) + sq_b_reg) : (sq_r_reg >> 1);

    assign rem_sh = {div_rem_reg, div_n_reg[DIVW-1]};
    assign q_bit  = rem_sh >= {1'b0, den_reg};

    always_comb begin
        unique case (state_reg)
            tdfc_pkg::ST_B_DX: div_src = 41'(vx_reg) <<< 18;
            tdfc_pkg::ST_B_DY: div_src = 41'(vy_reg) <<< 18;
            default:           div_src = 41'(prod_reg);
        endcase
    end

    assign div_abs  = div_src[40] ? 41'(-div_src) : 41'(div_src);
    assign div_init = DIVW'(div_abs) + DIVW'(den_reg >> 1);
    assign div_q    = div_neg_reg ? -$signed({1'b0, div_n_reg}) : $signed({1'b0, div_n_reg});

    always_comb begin
        if (div_q > (DIVW+1)'(tdfc_pkg::DIR_ONE)) begin
            dir_q = tdfc_pkg::DIR_ONE;
        end else if (div_q < -(DIVW+1)'(tdfc_pkg::DIR_ONE)) begin
            dir_q = -tdfc_pkg::DIR_ONE;
        end else begin
            dir_q = 16'(div_q);
        end
    end

    // ---- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tdfc_pkg::ST_IDLE:  if (s_valid) begin
                state_next = tdfc_pkg::ST_C_SQX;
            end
            tdfc_pkg::ST_C_SQX: state_next = tdfc_pkg::ST_C_SQY;
            tdfc_pkg::ST_C_SQY: state_next = tdfc_pkg::ST_C_R2;
            tdfc_pkg::ST_C_R2:  state_next = tdfc_pkg::ST_C_CMP;
            tdfc_pkg::ST_C_CMP: state_next = (sum_reg > 36'(prod_reg)) ?
                                             tdfc_pkg::ST_SQRT : tdfc_pkg::ST_B_VEC;
            tdfc_pkg::ST_C_MX:  state_next = tdfc_pkg::ST_C_DX;
            tdfc_pkg::ST_C_DX:  state_next = tdfc_pkg::ST_DIV;
            tdfc_pkg::ST_C_MY:  state_next = tdfc_pkg::ST_C_DY;
            tdfc_pkg::ST_C_DY:  state_next = tdfc_pkg::ST_DIV;
            tdfc_pkg::ST_C_FIN: state_next = tdfc_pkg::ST_B_VEC;
            tdfc_pkg::ST_SQRT:  if (sq_b_reg[0]) begin
                state_next = ret_reg;
            end
            tdfc_pkg::ST_DIV:   if (div_cnt_reg == DCW'(DIVW - 1)) begin
                state_next = ret_reg;
            end
            tdfc_pkg::ST_B_VEC: state_next = (vx_c == 18'sd0 && vy_c == 18'sd0) ?
                                             tdfc_pkg::ST_B_MX : tdfc_pkg::ST_B_SQX;
            tdfc_pkg::ST_B_SQX: state_next = tdfc_pkg::ST_B_SQY;
            tdfc_pkg::ST_B_SQY: state_next = tdfc_pkg::ST_B_SUM;
            tdfc_pkg::ST_B_SUM: state_next = tdfc_pkg::ST_SQRT;
            tdfc_pkg::ST_B_DX:  state_next = tdfc_pkg::ST_DIV;
            tdfc_pkg::ST_B_DY:  state_next = tdfc_pkg::ST_DIV;
            tdfc_pkg::ST_B_UY:  state_next = tdfc_pkg::ST_B_MX;
            tdfc_pkg::ST_B_MX:  state_next = tdfc_pkg::ST_B_MY;
            tdfc_pkg::ST_B_MY:  state_next = tdfc_pkg::ST_B_SY;
            tdfc_pkg::ST_B_SY:  state_next = (seg_reg == '0) ?
                                             tdfc_pkg::ST_F_OUT : tdfc_pkg::ST_B_VEC;
            tdfc_pkg::ST_F_OUT: if (out_free) begin
                state_next = tdfc_pkg::ST_F_MY;
            end
            tdfc_pkg::ST_F_MY:  state_next = tdfc_pkg::ST_F_NY;
            tdfc_pkg::ST_F_NY:  state_next = (seg_reg == SW'(N - 1)) ?
                                             tdfc_pkg::ST_IDLE : tdfc_pkg::ST_F_OUT;
            default:            state_next = tdfc_pkg::ST_IDLE;
        endcase
    end

    // ---- outputs and multiplier operands
    always_comb begin
        s_ready = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            tdfc_pkg::ST_IDLE:  s_ready = 1'b1;
            tdfc_pkg::ST_C_SQX: begin
                mul_a = 20'(dx_reg);
                mul_b = 20'(dx_reg);
            end
            tdfc_pkg::ST_C_SQY: begin
                mul_a = 20'(dy_reg);
                mul_b = 20'(dy_reg);
            end
            tdfc_pkg::ST_C_R2: begin
                mul_a = $signed({5'd0, reach_reg});
                mul_b = $signed({5'd0, reach_reg});
            end
            tdfc_pkg::ST_C_MX: begin
                mul_a = 20'(dx_reg);
                mul_b = $signed({1'b0, reach_reg, 4'd0});
            end
            tdfc_pkg::ST_C_MY: begin
                mul_a = 20'(dy_reg);
                mul_b = $signed({1'b0, reach_reg, 4'd0});
            end
            tdfc_pkg::ST_B_SQX: begin
                mul_a = 20'(vx_reg);
                mul_b = 20'(vx_reg);
            end
            tdfc_pkg::ST_B_SQY: begin
                mul_a = 20'(vy_reg);
                mul_b = 20'(vy_reg);
            end
            tdfc_pkg::ST_B_MX: begin
                mul_a = 20'(ux_reg);
                mul_b = $signed({6'd0, len_reg});
            end
            tdfc_pkg::ST_B_MY: begin
                mul_a = 20'(uy_reg);
                mul_b = $signed({6'd0, len_reg});
            end
            tdfc_pkg::ST_F_OUT: begin
                mul_a = 20'(dir_x_reg[seg_reg]);
                mul_b = $signed({6'd0, len_reg});
            end
            tdfc_pkg::ST_F_MY: begin
                mul_a = 20'(dir_y_reg[seg_reg]);
                mul_b = $signed({6'd0, len_reg});
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---- control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdfc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            root_x_reg  <= tdfc_pkg::ROOT_RESET;
            root_y_reg  <= tdfc_pkg::ROOT_RESET;
            len_reg     <= tdfc_pkg::LEN_RESET;
            reach_reg   <= tdfc_pkg::REACH_RESET;
            for (int i = 0; i < N; i++) begin
                start_x_reg[i] <= 16'(tdfc_pkg::ROOT_RESET);
                start_y_reg[i] <= 16'(tdfc_pkg::ROOT_RESET);
                dir_x_reg[i]   <= tdfc_pkg::DIR_ONE;
                dir_y_reg[i]   <= 16'sd0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (tdfc_pkg::cfg_idx_t'(cfg_index))
                    tdfc_pkg::CFG_ROOT_X:      root_x_reg <= cfg_wdata[13:0];
                    tdfc_pkg::CFG_ROOT_Y:      root_y_reg <= cfg_wdata[13:0];
                    tdfc_pkg::CFG_SEG_LENGTH:  len_reg    <= cfg_wdata[13:0];
                    tdfc_pkg::CFG_REACH_LIMIT: reach_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (state_reg == tdfc_pkg::ST_F_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == tdfc_pkg::ST_B_MY) begin
                start_x_reg[seg_reg] <= sub_sat;
                dir_x_reg[seg_reg]   <= ux_reg;
            end
            if (state_reg == tdfc_pkg::ST_B_SY) begin
                start_y_reg[seg_reg] <= sub_sat;
                dir_y_reg[seg_reg]   <= uy_reg;
            end
            if (state_reg == tdfc_pkg::ST_F_OUT && out_free) begin
                start_x_reg[seg_reg] <= 16'(px_reg);
                start_y_reg[seg_reg] <= 16'(py_reg);
            end
        end
    end

    // ---- datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            tdfc_pkg::ST_IDLE: begin
                dx_reg <= $signed({2'd0, s_data.target_x, 4'd0}) - $signed({2'd0, root_x_reg});
                dy_reg <= $signed({2'd0, s_data.target_y, 4'd0}) - $signed({2'd0, root_y_reg});
            end
            tdfc_pkg::ST_C_SQY: sum_reg <= 36'(prod_reg);
            tdfc_pkg::ST_C_R2:  sum_reg <= sum_add;
            tdfc_pkg::ST_C_CMP: begin
                sq_v_reg <= {sum_reg, 8'd0};
                sq_r_reg <= '0;
                sq_b_reg <= SQW'(1) << (SQW - 2);
                ret_reg  <= tdfc_pkg::ST_C_MX;
                px_reg   <= 17'(root_x_reg) + 17'(dx_reg);
                py_reg   <= 17'(root_y_reg) + 17'(dy_reg);
                seg_reg  <= SW'(N - 1);
            end
            tdfc_pkg::ST_C_DX, tdfc_pkg::ST_C_DY, tdfc_pkg::ST_B_DX, tdfc_pkg::ST_B_DY: begin
                div_n_reg   <= div_init;
                div_neg_reg <= div_src[40];
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
                if (state_reg == tdfc_pkg::ST_C_DX) begin
                    ret_reg <= tdfc_pkg::ST_C_MY;
                end else if (state_reg == tdfc_pkg::ST_C_DY) begin
                    ret_reg <= tdfc_pkg::ST_C_FIN;
                end else if (state_reg == tdfc_pkg::ST_B_DX) begin
                    ret_reg <= tdfc_pkg::ST_B_DY;
                end else begin
                    ux_reg  <= dir_q;
                    ret_reg <= tdfc_pkg::ST_B_UY;
                end
            end
            tdfc_pkg::ST_C_MY:  dx_reg <= 16'(div_q);
            tdfc_pkg::ST_C_FIN: begin
                px_reg  <= 17'(root_x_reg) + 17'(dx_reg);
                py_reg  <= 17'(root_y_reg) + 17'(div_q);
                seg_reg <= SW'(N - 1);
            end
            tdfc_pkg::ST_SQRT: begin
                if (sq_ge) begin
                    sq_v_reg <= sq_v_reg - sq_t;
                end
                sq_r_reg <= sq_r_next;
                sq_b_reg <= sq_b_reg >> 2;
                den_reg  <= DENW'(sq_r_next);
            end
            tdfc_pkg::ST_DIV: begin
                div_rem_reg <= q_bit ? DENW'(rem_sh - {1'b0, den_reg}) : DENW'(rem_sh);
                div_n_reg   <= {div_n_reg[DIVW-2:0], q_bit};
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
            tdfc_pkg::ST_B_VEC: begin
                vx_reg <= vx_c;
                vy_reg <= vy_c;
                ux_reg <= tdfc_pkg::DIR_ONE;
                uy_reg <= 16'sd0;
            end
            tdfc_pkg::ST_B_SQY: sum_reg <= 36'(prod_reg);
            tdfc_pkg::ST_B_SUM: begin
                sq_v_reg <= {sum_add, 8'd0};
                sq_r_reg <= '0;
                sq_b_reg <= SQW'(1) << (SQW - 2);
                ret_reg  <= tdfc_pkg::ST_B_DX;
            end
            tdfc_pkg::ST_B_UY:  uy_reg <= dir_q;
            tdfc_pkg::ST_B_MY:  px_reg <= 17'(sub_sat);
            tdfc_pkg::ST_B_SY: begin
                if (seg_reg == '0) begin
                    px_reg <= 17'(root_x_reg);
                    py_reg <= 17'(root_y_reg);
                end else begin
                    py_reg  <= 17'(sub_sat);
                    seg_reg <= seg_reg - SW'(1);
                end
            end
            tdfc_pkg::ST_F_OUT: begin
                if (out_free) begin
                    m_data_reg.point_x <= 16'(px_reg);
                    m_data_reg.point_y <= 16'(py_reg);
                    m_data_reg.is_last <= (seg_reg == SW'(N - 1));
                end
            end
            tdfc_pkg::ST_F_MY:  px_reg <= 17'(add_sat);
            tdfc_pkg::ST_F_NY: begin
                py_reg <= 17'(add_sat);
                if (seg_reg != SW'(N - 1)) begin
                    seg_reg <= seg_reg + SW'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sim/chain_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chain_checker
// Watches the target and point channels of the follow chain, predicts every
// segment start point of each accepted target and compares it with the block.
// ----------------------------------------------------------------------------
module chain_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  tdfc_pkg::in_item_t            s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  tdfc_pkg::out_item_t           m_data,
    input  logic                          cfg_we,
    input  logic [tdfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tdfc_pkg::CFG_W-1:0]    cfg_wdata,
    output int                            errors,
    output int                            pending
);

    localparam longint ONE = 16384;
    localparam int NS = tdfc_pkg::NUM_SEGS;

    longint root_x, root_y, seg_len, reach;
    longint pos_x [NS];
    longint pos_y [NS];
    longint aim_x [NS];
    longint aim_y [NS];
    tdfc_pkg::out_item_t expected_points [$];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint rdiv(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic longint mag16(longint x, longint y);
        longint unsigned s;
        s = longint'(x * x) + longint'(y * y);
        return longint'(isqrt(s << 8));
    endfunction

    task automatic solve_chain(tdfc_pkg::in_item_t it);
        longint dx, dy, px, py, vx, vy, m, k, ux, uy;
        tdfc_pkg::out_item_t p;
        dx = (longint'(it.target_x) << 4) - root_x;
        dy = (longint'(it.target_y) << 4) - root_y;
        if (dx * dx + dy * dy > reach * reach) begin
            m = mag16(dx, dy);
            k = reach * 16;
            dx = rdiv(dx * k, m);
            dy = rdiv(dy * k, m);
        end
        px = root_x + dx;
        py = root_y + dy;
        for (int i = NS - 1; i >= 0; i--) begin
            vx = px - pos_x[i];
            vy = py - pos_y[i];
            if (vx == 0 && vy == 0) begin
                ux = ONE;
                uy = 0;
            end else begin
                m = mag16(vx, vy);
                ux = clamp_unit(rdiv(vx * 262144, m));
                uy = clamp_unit(rdiv(vy * 262144, m));
            end
            aim_x[i] = ux;
            aim_y[i] = uy;
            pos_x[i] = sat16(px - rdiv(ux * seg_len, ONE));
            pos_y[i] = sat16(py - rdiv(uy * seg_len, ONE));
            px = pos_x[i];
            py = pos_y[i];
        end
        px = root_x;
        py = root_y;
        for (int i = 0; i < NS; i++) begin
            pos_x[i] = sat16(px);
            pos_y[i] = sat16(py);
            p.point_x = 16'(pos_x[i]);
            p.point_y = 16'(pos_y[i]);
            p.is_last = (i == NS - 1);
            expected_points.push_back(p);
            px = sat16(pos_x[i] + rdiv(aim_x[i] * seg_len, ONE));
            py = sat16(pos_y[i] + rdiv(aim_y[i] * seg_len, ONE));
        end
    endtask

    initial begin
        errors = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        tdfc_pkg::out_item_t want;
        if (!aresetn) begin
            root_x = tdfc_pkg::ROOT_RESET;
            root_y = tdfc_pkg::ROOT_RESET;
            seg_len = tdfc_pkg::LEN_RESET;
            reach = tdfc_pkg::REACH_RESET;
            for (int i = 0; i < NS; i++) begin
                pos_x[i] = tdfc_pkg::ROOT_RESET;
                pos_y[i] = tdfc_pkg::ROOT_RESET;
                aim_x[i] = ONE;
                aim_y[i] = 0;
            end
            expected_points.delete();
        end else begin
            if (cfg_we) begin
                case (tdfc_pkg::cfg_idx_t'(cfg_index))
                    tdfc_pkg::CFG_ROOT_X:      root_x = cfg_wdata & 15'h3FFF;
                    tdfc_pkg::CFG_ROOT_Y:      root_y = cfg_wdata & 15'h3FFF;
                    tdfc_pkg::CFG_SEG_LENGTH:  seg_len = cfg_wdata & 15'h3FFF;
                    tdfc_pkg::CFG_REACH_LIMIT: reach = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) solve_chain(s_data);
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected point x=%0d y=%0d last=%0b",
                                 m_data.point_x, m_data.point_y, m_data.is_last);
                end else begin
                    want = expected_points.pop_front();
                    if (m_data !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("point mismatch: exp %0d,%0d,%0b got %0d,%0d,%0b",
                                     want.point_x, want.point_y, want.is_last,
                                     m_data.point_x, m_data.point_y, m_data.is_last);
                    end
                end
            end
        end
        pending = expected_points.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Target stimulus and verdict for the two-dimensional follow chain IK block.
// Directed targets at the corners and at the root, then random targets
// across several root, length and reach settings, with random idle bursts
// on both channels and one long and one short output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    tdfc_pkg::in_item_t             s_data;
    logic                           m_valid;
    logic                           m_ready;
    tdfc_pkg::out_item_t            m_data;
    logic                           cfg_we;
    logic [tdfc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tdfc_pkg::CFG_W-1:0]     cfg_wdata;
    int                             errors;
    int                             pending;
    int                             targets_sent;
    int                             settings_used;
    bit                             idling;
    int                             hold_cycles;

    two_d_follow_chain_ik uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    chain_checker chain_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic send_target(int tx, int ty);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data.target_x = 10'(tx);
        s_data.target_y = 10'(ty);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        targets_sent++;
    endtask

    task automatic drain;
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_reg(tdfc_pkg::cfg_idx_t idx, int value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = tdfc_pkg::CFG_W'(value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_chain(int rx, int ry, int len, int lim);
        drain();
        write_reg(tdfc_pkg::CFG_ROOT_X, rx);
        write_reg(tdfc_pkg::CFG_ROOT_Y, ry);
        write_reg(tdfc_pkg::CFG_SEG_LENGTH, len);
        write_reg(tdfc_pkg::CFG_REACH_LIMIT, lim);
        settings_used++;
    endtask

    task automatic random_targets(int n);
        int near_x, near_y;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                near_x = $urandom_range(380, 420);
                near_y = $urandom_range(380, 420);
                send_target(near_x, near_y);
            end else begin
                send_target($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
        end
    endtask

    // receiver: hold-off on request, otherwise random stall bursts while idling is set
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        targets_sent = 0;
        settings_used = 1;
        idling = 1'b1;
        hold_cycles = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: target on the root gives zero-length aims
        send_target(400, 400);
        send_target(400, 400);
        send_target(0, 0);
        send_target(1023, 1023);
        send_target(0, 1023);
        send_target(1023, 0);
        send_target(401, 400);
        send_target(410, 395);

        // hold longer than one solve so points back up and the input stalls
        hold_cycles = 8000;
        send_target(700, 200);
        send_target(100, 900);

        // zero reach: aim point is the root
        set_chain(6400, 6400, 16, 0);
        send_target(1023, 1023);
        send_target(0, 0);
        // full reach, longest segments, masked root writes
        set_chain(32767, 32767, 16383, 32767);
        send_target(1023, 1023);
        send_target(0, 0);
        send_target(512, 77);
        // root at origin, unit segments
        set_chain(0, 0, 1, 32767);
        send_target(0, 0);
        send_target(1023, 1023);
        send_target(3, 700);
        // zero length collapses the chain
        set_chain(8000, 100, 0, 1000);
        send_target(600, 5);
        send_target(500, 1023);

        set_chain(6400, 6400, 16, 512);
        random_targets(30);
        set_chain($urandom_range(0, 16383), $urandom_range(0, 16383),
                  $urandom_range(1, 400), $urandom_range(0, 32767));
        random_targets(20);
        set_chain(16383, 0, 16383, 32767);
        random_targets(20);
        set_chain($urandom_range(0, 16383), $urandom_range(0, 16383),
                  $urandom_range(1, 16383), $urandom_range(0, 4000));
        hold_cycles = 300;
        random_targets(20);
        idling = 1'b0;
        set_chain(6400, 6400, 40, 2000);
        random_targets(30);

        drain();
        $display("Sent %0d targets over %0d chain settings (reach clamp, zero aim, saturation).",
                 targets_sent, settings_used);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
